>>> rtl/core/prefix_code_table_decoder_assert.svh
// Assertion macros for the prefix-code table decoder checker.
// Assumes clk and rst_n are visible in the scope where the macros are used.
`ifndef PREFIX_CODE_TABLE_DECODER_ASSERT_SVH
`define PREFIX_CODE_TABLE_DECODER_ASSERT_SVH

// Same-cycle implication.
`define PCTD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pctd_pkg.sv
// Package for the prefix-code table decoder: field widths, op codes and
// the structs passed between the controller and the cell row. No dependencies.
`timescale 1ns / 1ps

package pctd_pkg;

  localparam int SYM_W  = 8;
  localparam int LEN_W  = 6;
  localparam int CODE_W = 32;
  localparam int IDX_W  = 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_BIT  = 1'b1;

  // Broadcast table write to every cell.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  index;
    logic [LEN_W-1:0]  length;
    logic [CODE_W-1:0] code;
    logic [SYM_W-1:0]  symbol;
  } pctd_load_t;

  // Probe token walking down the cell row.
  typedef struct packed {
    logic             active;
    logic             found;
    logic [SYM_W-1:0] symbol;
  } pctd_token_t;

endpackage

>>> rtl/core/pctd_stream_if.sv
// Valid/ready channel interfaces for the prefix-code table decoder.
// Depends on pctd_pkg for field widths.
`timescale 1ns / 1ps

interface pctd_in_if;
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic [pctd_pkg::IDX_W-1:0]      entry_index;
  logic [pctd_pkg::LEN_W-1:0]      code_length;
  logic [pctd_pkg::CODE_W-1:0]     code_value;
  logic [pctd_pkg::SYM_W-1:0]      symbol_in;
  logic                            coded_bit;

  modport source (
    output valid, op, entry_index, code_length, code_value, symbol_in, coded_bit,
    input  ready
  );
  modport sink (
    input  valid, op, entry_index, code_length, code_value, symbol_in, coded_bit,
    output ready
  );
endinterface

interface pctd_out_if;
  logic                        valid;
  logic                        ready;
  logic [pctd_pkg::SYM_W-1:0]  symbol_out;
  logic                        overflow;

  modport source (output valid, symbol_out, overflow, input ready);
  modport sink   (input valid, symbol_out, overflow, output ready);
endinterface

>>> rtl/core/prefix_code_table_decoder.sv
// Prefix-code table decoder, top level. Depends on pctd_pkg, pctd_stream_if
// and pctd_cell.
//
// Usage:
//  - in_ch carries two kinds of word. op = load writes one table slot
//    (entry_index, code_length, code_value, symbol_in); code_length 0 clears
//    the slot and slots at or above TABLE_SLOTS are ignored. op = bit shifts
//    coded_bit into the partial code.
//  - out_ch carries one word per decoded symbol, or an overflow word
//    (symbol_out 0) when MAX_CODE_BITS bits went by without a match.
//  - Load words do not stall the input and never produce output.
//  - A bit word runs one probe down the row of TABLE_SLOTS cells, one cell
//    per cycle; the input takes no new word until the probe has left the
//    last cell and any result has been loaded into the output register,
//    so the length of the cell row sets how long a bit word holds it.
//  - The output register lets the block accept words while a result waits;
//    if a new result is due while the old one is still stalled, the block
//    holds it and stops accepting until out_ch.ready frees the register.
//  - Reset (rst_n low, synchronous) clears every slot's valid bit, the
//    partial code and the output register's valid bit.
`timescale 1ns / 1ps

module prefix_code_table_decoder #(
  parameter int TABLE_SLOTS   = 256,
  parameter int MAX_CODE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  pctd_in_if.sink           in_ch,
  pctd_out_if.source        out_ch
);

  // Compare widths cover both the loaded code and the partial code.
  localparam int CMP_W  = (MAX_CODE_BITS > pctd_pkg::CODE_W) ? MAX_CODE_BITS
                                                             : pctd_pkg::CODE_W;
  localparam int PLEN_W = $clog2(MAX_CODE_BITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;  // taking words
  localparam logic [1:0] ST_SCAN = 2'd1;  // probe walking the row
  localparam logic [1:0] ST_DONE = 2'd2;  // post result, clear partial code

  logic [1:0]                  state_r, state_nxt;
  logic [MAX_CODE_BITS-1:0]    pcode_r, pcode_nxt;
  logic [PLEN_W-1:0]           plen_r, plen_nxt;
  logic                        inject_r;
  logic                        hit_r, hit_nxt;
  logic [pctd_pkg::SYM_W-1:0]  hsym_r, hsym_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [pctd_pkg::SYM_W-1:0]  out_sym_r, out_sym_nxt;
  logic                        out_ovf_r, out_ovf_nxt;
  logic                        out_load;

  logic                        in_ready;
  logic                        in_fire;
  logic                        bit_fire;
  logic                        need_result;
  logic [CMP_W-1:0]            pcode_cmp;
  pctd_pkg::pctd_load_t        ld;
  pctd_pkg::pctd_token_t       tok [TABLE_SLOTS+1];
  pctd_pkg::pctd_token_t       tail;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_ch.valid && in_ready;
  assign bit_fire = in_fire && (in_ch.op == pctd_pkg::OP_BIT);

  assign in_ch.ready = in_ready;

  // Table writes go straight from the input word to all cells.
  assign ld.we     = in_fire && (in_ch.op == pctd_pkg::OP_LOAD);
  assign ld.index  = in_ch.entry_index;
  assign ld.length = in_ch.code_length;
  assign ld.code   = in_ch.code_value;
  assign ld.symbol = in_ch.symbol_in;

  assign pcode_cmp = CMP_W'(pcode_r);

  // Probe enters at slot 0 the cycle after a bit word is taken.
  assign tok[0] = '{active: inject_r, found: 1'b0, symbol: '0};
  assign tail   = tok[TABLE_SLOTS];

  for (genvar gi = 0; gi < TABLE_SLOTS; gi++) begin : g_cell
    pctd_cell #(
      .CELL_INDEX (gi),
      .CMP_W      (CMP_W),
      .PLEN_W     (PLEN_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ld      (ld),
      .pcode   (pcode_cmp),
      .plen    (plen_r),
      .tok_in  (tok[gi]),
      .tok_out (tok[gi+1])
    );
  end

  assign need_result = hit_r || (plen_r == PLEN_W'(MAX_CODE_BITS));
  assign out_load    = (state_r == ST_DONE) && need_result &&
                       (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    pcode_nxt = pcode_r;
    plen_nxt  = plen_r;
    hit_nxt   = hit_r;
    hsym_nxt  = hsym_r;
    case (state_r)
      ST_IDLE: begin
        if (bit_fire) begin
          pcode_nxt = {pcode_r[MAX_CODE_BITS-2:0], in_ch.coded_bit};
          plen_nxt  = plen_r + PLEN_W'(1);
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail.active) begin
          hit_nxt   = tail.found;
          hsym_nxt  = tail.symbol;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!need_result) begin
          state_nxt = ST_IDLE;
        end else if (out_load) begin
          pcode_nxt = '0;
          plen_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: drains on ready, refills from a finished probe.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_sym_nxt   = out_sym_r;
    out_ovf_nxt   = out_ovf_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_sym_nxt   = hit_r ? hsym_r : '0;
      out_ovf_nxt   = !hit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pcode_r     <= '0;
      plen_r      <= '0;
      inject_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pcode_r     <= pcode_nxt;
      plen_r      <= plen_nxt;
      inject_r    <= bit_fire;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r     <= hit_nxt;
    hsym_r    <= hsym_nxt;
    out_sym_r <= out_sym_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.symbol_out = out_sym_r;
  assign out_ch.overflow   = out_ovf_r;

endmodule

>>> rtl/core/pctd_cell.sv
// One table slot of the decoder row: holds an entry and checks it against
// the partial code as the probe token passes. Depends on pctd_pkg.
`timescale 1ns / 1ps

module pctd_cell #(
  parameter int CELL_INDEX = 0,
  parameter int CMP_W      = 32,
  parameter int PLEN_W     = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pctd_pkg::pctd_load_t  ld,
  input  logic [CMP_W-1:0]      pcode,
  input  logic [PLEN_W-1:0]     plen,
  input  pctd_pkg::pctd_token_t tok_in,
  output pctd_pkg::pctd_token_t tok_out
);

  localparam int LCMP_W = (PLEN_W > pctd_pkg::LEN_W) ? PLEN_W : pctd_pkg::LEN_W;

  logic                          valid_r;
  logic [pctd_pkg::LEN_W-1:0]    len_r;
  logic [pctd_pkg::CODE_W-1:0]   code_r;
  logic [pctd_pkg::SYM_W-1:0]    sym_r;
  logic [pctd_pkg::CODE_W-1:0]   code_mask;
  logic                          write_en;
  logic                          hit;
  pctd_pkg::pctd_token_t         tok_r;
  pctd_pkg::pctd_token_t         tok_nxt;

  assign write_en = ld.we && (int'(ld.index) == CELL_INDEX);

  // Keep only the low code_length bits of the loaded code.
  always_comb begin
    for (int k = 0; k < pctd_pkg::CODE_W; k++) begin
      code_mask[k] = (k < int'(ld.length));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (write_en) begin
      valid_r <= (ld.length != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      len_r  <= ld.length;
      code_r <= ld.code & code_mask;
      sym_r  <= ld.symbol;
    end
  end

  assign hit = tok_in.active && valid_r &&
               (LCMP_W'(len_r) == LCMP_W'(plen)) &&
               (CMP_W'(code_r) == pcode);

  // First hit along the row keeps its symbol: lowest slot wins.
  always_comb begin
    tok_nxt.active = tok_in.active;
    tok_nxt.found  = tok_in.found | hit;
    tok_nxt.symbol = tok_in.found ? tok_in.symbol : sym_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

>>> rtl/core/pctd_checker.sv
// Port-level checker for the prefix-code table decoder, bound to the top.
// Depends on pctd_pkg and prefix_code_table_decoder_assert.svh.
`timescale 1ns / 1ps
`include "prefix_code_table_decoder_assert.svh"

module pctd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_op,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pctd_pkg::SYM_W-1:0]  out_symbol,
  input logic                        out_overflow
);

  // Stalled result word stays up.
  `PCTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out word dropped while stalled")

  // Overflow words carry a zero symbol.
  `PCTD_ASSERT_NOW(a_ovf_sym, out_valid && out_overflow, out_symbol == '0, "overflow with symbol")

  // A bit word starts a scan: no new word next cycle.
  `PCTD_ASSERT_NEXT(a_bit_busy, in_valid && in_ready && (in_op == pctd_pkg::OP_BIT), !in_ready, "ready during scan")

  // Table loads leave the input ready for the next word.
  `PCTD_ASSERT_NEXT(a_load_fast, in_valid && in_ready && (in_op == pctd_pkg::OP_LOAD), in_ready, "load stalled input")

endmodule

bind prefix_code_table_decoder pctd_checker u_pctd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_op        (in_ch.op),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_symbol   (out_ch.symbol_out),
  .out_overflow (out_ch.overflow)
);
